// File: rtl/rhsv_pkg.sv
// shared widths, constants and types of the rgb to hsv converter
`default_nettype none

package rhsv_pkg;

    // field widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int PCT_W  = 13;

    // divider lanes: numerator, divisor, quotient widths and pipeline depth
    localparam int NUM_W      = 22;
    localparam int DEN_W      = 9;
    localparam int QUO_W      = 16;
    localparam int DIV_STAGES = 4;

    // fixed-point constants, 6 fractional bits
    localparam logic [HUE_W-1:0] HUE_SIXTH = HUE_W'(3840);   // 60 degrees
    localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(23040);  // 360 degrees
    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(6400);   // 100 percent

    // doubled gains for round-to-nearest numerators (2*n + den) / (2*den)
    localparam logic [NUM_W-1:0] HUE_GAIN = NUM_W'(2 * 3840);
    localparam logic [NUM_W-1:0] PCT_GAIN = NUM_W'(2 * 6400);

    // value as 25*max + round(25*max/255), since 6400 = 25*255 + 25
    // the rounded part is (25*max + 127) / 255, taken as a reciprocal product
    localparam int                    VAL_PROD_W = 30;
    localparam int                    VAL_SHIFT  = 24;
    localparam logic [PCT_W-1:0]      VAL_STEP   = PCT_W'(25);
    localparam logic [PCT_W-1:0]      VAL_HALF   = PCT_W'(127);
    localparam logic [VAL_PROD_W-1:0] VAL_RECIP  = VAL_PROD_W'(65794);  // ceil(2^24/255)

    // hue sector: base hue is the sector index times 60 degrees
    typedef enum logic [2:0] {
        SEC_R_G = 3'd0,   // red max, green at or above blue
        SEC_G_R = 3'd1,   // green max, red above blue
        SEC_G_B = 3'd2,   // green max, blue at or above red
        SEC_B_G = 3'd3,   // blue max, green above red
        SEC_B_R = 3'd4,   // blue max, red at or above green
        SEC_R_B = 3'd5    // red max, blue above green
    } sector_t;

endpackage

`default_nettype wire

// File: rtl/rhsv_pix_if.sv
// pixel channel: valid/ready with one rgb item
`default_nettype none

interface rhsv_pix_if import rhsv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: rtl/rhsv_hsv_if.sv
// result channel: valid/ready with one hsv item
`default_nettype none

interface rhsv_hsv_if import rhsv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/rgb_to_hsv.sv
// rgb to hsv converter top level: pixel in, hue/saturation/value out
//
// Converts one 8-bit RGB pixel per item into hue (degrees), saturation and
// value (percent), each unsigned with 6 fractional bits and rounded to nearest.
// The block accepts one item every clock cycle while results are taken, and
// offers the result of an item through seven register stages: one for
// max/min and hue sector, one for the division operands, four for the dividers
// (16 quotient bits, four per stage) and the output register. Hue and saturation
// each have a divider lane; value divides by a constant and is formed from a
// reciprocal product that rides along the same stages. Every stage holds its own
// valid bit, so bubbles close up and a stall on the result side backs up without
// losing or repeating items; there is no state to clear after reset.
`default_nettype none

module rgb_to_hsv import rhsv_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    rhsv_pix_if.sink     pixel,
    rhsv_hsv_if.source   hsv
);

    // front, operand, divider and output stages
    localparam int NS = DIV_STAGES + 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] take;

    // stage 0: max, min, spread and sector
    logic [CHAN_W-1:0] mx_next, mn_next, d_next, p_next;
    sector_t           sec_next;
    logic [CHAN_W-1:0] mx_reg, d_reg, p_reg;
    sector_t           sec_reg [NS-1];

    // stage 1: divider operands
    logic [NUM_W-1:0] hue_num_next, sat_num_next;
    logic [DEN_W-1:0] hue_den_next, sat_den_next;
    logic [NUM_W-1:0] hue_num_reg, sat_num_reg;
    logic [DEN_W-1:0] hue_den_reg, sat_den_reg;

    // value lane: base and rounding operand, then the reciprocal product
    logic [PCT_W-1:0]      val_base_next, val_y_next;
    logic [PCT_W-1:0]      val_base_reg, val_y_reg;
    logic [VAL_PROD_W-1:0] val_prod;
    logic [PCT_W-1:0]      val_next;
    logic [PCT_W-1:0]      val_pipe_reg [DIV_STAGES];

    // divider results and output stage
    logic [QUO_W-1:0] hue_quo, sat_quo;
    logic [HUE_W-1:0] hue_sum;
    logic [HUE_W-1:0] hue_next, hue_reg;
    logic [PCT_W-1:0] sat_reg, val_reg;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        take[NS-1] = !valid_reg[NS-1] || hsv.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            take[i] = !valid_reg[i] || take[i+1];
        end
    end

    assign pixel.ready = take[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (take[0])
            begin
                valid_reg[0] <= pixel.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (take[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // max/min and sector; p is the position inside the sector, 0..d
    always_comb
    begin
        mx_next = pixel.red;
        mn_next = pixel.red;
        if (pixel.green > mx_next) mx_next = pixel.green;
        if (pixel.blue > mx_next)  mx_next = pixel.blue;
        if (pixel.green < mn_next) mn_next = pixel.green;
        if (pixel.blue < mn_next)  mn_next = pixel.blue;
        d_next = mx_next - mn_next;
        priority if (mx_next == pixel.red)
        begin
            if (pixel.green >= pixel.blue)
            begin
                sec_next = SEC_R_G;
                p_next   = pixel.green - pixel.blue;
            end
            else
            begin
                sec_next = SEC_R_B;
                p_next   = d_next - pixel.blue + pixel.green;
            end
        end
        else if (mx_next == pixel.green)
        begin
            if (pixel.blue >= pixel.red)
            begin
                sec_next = SEC_G_B;
                p_next   = pixel.blue - pixel.red;
            end
            else
            begin
                sec_next = SEC_G_R;
                p_next   = d_next - pixel.red + pixel.blue;
            end
        end
        else
        begin
            if (pixel.red >= pixel.green)
            begin
                sec_next = SEC_B_R;
                p_next   = pixel.red - pixel.green;
            end
            else
            begin
                sec_next = SEC_B_G;
                p_next   = d_next - pixel.green + pixel.red;
            end
        end
    end

    // rounding numerators (2*gain*x + den) over 2*den; zero divisors become one
    always_comb
    begin
        hue_num_next  = (HUE_GAIN * NUM_W'(p_reg)) + NUM_W'(d_reg);
        hue_den_next  = (d_reg == '0) ? DEN_W'(1) : {d_reg, 1'b0};
        sat_num_next  = (PCT_GAIN * NUM_W'(d_reg)) + NUM_W'(mx_reg);
        sat_den_next  = (mx_reg == '0) ? DEN_W'(1) : {mx_reg, 1'b0};
        val_base_next = VAL_STEP * PCT_W'(mx_reg);
        val_y_next    = val_base_next + VAL_HALF;
    end

    // value: base plus (25*max + 127) / 255 by reciprocal product
    always_comb
    begin
        val_prod = VAL_PROD_W'(val_y_reg) * VAL_RECIP;
        val_next = val_base_reg + PCT_W'(val_prod[VAL_PROD_W-1:VAL_SHIFT]);
    end

    // payload registers of the front and operand stages, sector and value pipes
    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            mx_reg     <= mx_next;
            d_reg      <= d_next;
            p_reg      <= p_next;
            sec_reg[0] <= sec_next;
        end
        if (take[1])
        begin
            hue_num_reg  <= hue_num_next;
            hue_den_reg  <= hue_den_next;
            sat_num_reg  <= sat_num_next;
            sat_den_reg  <= sat_den_next;
            val_base_reg <= val_base_next;
            val_y_reg    <= val_y_next;
        end
        for (int i = 1; i < NS - 1; i++)
        begin
            if (take[i])
            begin
                sec_reg[i] <= sec_reg[i-1];
            end
        end
        if (take[2])
        begin
            val_pipe_reg[0] <= val_next;
        end
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            if (take[i+2])
            begin
                val_pipe_reg[i] <= val_pipe_reg[i-1];
            end
        end
    end

    // divider lanes
    rhsv_div #(
        .NUM_W_P  (NUM_W),
        .DEN_W_P  (DEN_W),
        .QUO_W_P  (QUO_W),
        .STAGES_P (DIV_STAGES)
    ) u_hue_div (
        .clk  (clk),
        .take (take[DIV_STAGES+1:2]),
        .num  (hue_num_reg),
        .den  (hue_den_reg),
        .quo  (hue_quo)
    );

    rhsv_div #(
        .NUM_W_P  (NUM_W),
        .DEN_W_P  (DEN_W),
        .QUO_W_P  (QUO_W),
        .STAGES_P (DIV_STAGES)
    ) u_sat_div (
        .clk  (clk),
        .take (take[DIV_STAGES+1:2]),
        .num  (sat_num_reg),
        .den  (sat_den_reg),
        .quo  (sat_quo)
    );

    // sector base plus rounded offset; a full turn wraps to zero
    always_comb
    begin
        hue_sum  = (HUE_SIXTH * HUE_W'(sec_reg[NS-2])) + hue_quo[HUE_W-1:0];
        hue_next = (hue_sum >= HUE_FULL) ? hue_sum - HUE_FULL : hue_sum;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (take[NS-1])
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_quo[PCT_W-1:0];
            val_reg <= val_pipe_reg[DIV_STAGES-1];
        end
    end

    assign hsv.valid      = valid_reg[NS-1];
    assign hsv.hue        = hue_reg;
    assign hsv.saturation = sat_reg;
    assign hsv.brightness = val_reg;

    // hue stays below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid |-> (hsv.hue < HUE_FULL))
        else $error("hue out of range");

    // percentages never exceed one hundred
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid |-> (hsv.saturation <= PCT_FULL && hsv.brightness <= PCT_FULL))
        else $error("percent out of range");

    // a grey item sits at the start of the first sector with no offset
    a_grey_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && d_reg == '0) |-> (p_reg == '0 && sec_reg[0] == SEC_R_G))
        else $error("grey item with nonzero hue offset");

    // a stalled front stage with a full successor keeps its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !take[0]) |=> (valid_reg[0] && $stable(d_reg) && $stable(p_reg)))
        else $error("front stage lost an item under stall");

endmodule

`default_nettype wire

// File: rtl/rhsv_div.sv
// pipelined restoring divider, a fixed number of quotient bits per stage
`default_nettype none

module rhsv_div import rhsv_pkg::*; #(
    parameter int NUM_W_P  = NUM_W,
    parameter int DEN_W_P  = DEN_W,
    parameter int QUO_W_P  = QUO_W,
    parameter int STAGES_P = DIV_STAGES
) (
    input  logic               clk,
    input  logic [STAGES_P-1:0] take,
    input  logic [NUM_W_P-1:0] num,
    input  logic [DEN_W_P-1:0] den,
    output logic [QUO_W_P-1:0] quo
);

    // quotient bits resolved in one stage
    localparam int STEPS = (QUO_W_P + STAGES_P - 1) / STAGES_P;

    logic [DEN_W_P-1:0] rem_reg  [STAGES_P];
    logic [DEN_W_P-1:0] rem_next [STAGES_P];
    logic [QUO_W_P-1:0] sh_reg   [STAGES_P];
    logic [QUO_W_P-1:0] sh_next  [STAGES_P];
    logic [DEN_W_P-1:0] den_reg  [STAGES_P];
    logic [DEN_W_P-1:0] den_src  [STAGES_P];
    logic [DEN_W_P-1:0] rem_src  [STAGES_P];
    logic [QUO_W_P-1:0] sh_src   [STAGES_P];

    // stage inputs: the operands for the first stage, the previous stage after that
    // the quotient is known to fit, so the upper numerator bits start below den
    always_comb
    begin
        rem_src[0] = DEN_W_P'(num >> QUO_W_P);
        sh_src[0]  = num[QUO_W_P-1:0];
        den_src[0] = den;
        for (int s = 1; s < STAGES_P; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            sh_src[s]  = sh_reg[s-1];
            den_src[s] = den_reg[s-1];
        end
    end

    // shift-subtract steps; quotient bits fill the shift word from the bottom
    always_comb
    begin
        logic [DEN_W_P-1:0] rem_v;
        logic [QUO_W_P-1:0] sh_v;
        logic [DEN_W_P:0]   trial;
        logic               qbit;
        for (int s = 0; s < STAGES_P; s++)
        begin
            rem_v = rem_src[s];
            sh_v  = sh_src[s];
            for (int k = 0; k < STEPS; k++)
            begin
                if (s * STEPS + k < QUO_W_P)
                begin
                    trial = {rem_v, sh_v[QUO_W_P-1]};
                    qbit  = (trial >= {1'b0, den_src[s]});
                    if (qbit)
                    begin
                        trial = trial - {1'b0, den_src[s]};
                    end
                    rem_v = trial[DEN_W_P-1:0];
                    sh_v  = {sh_v[QUO_W_P-2:0], qbit};
                end
            end
            rem_next[s] = rem_v;
            sh_next[s]  = sh_v;
        end
    end

    // stage registers advance on their own enable
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES_P; s++)
        begin
            if (take[s])
            begin
                rem_reg[s] <= rem_next[s];
                sh_reg[s]  <= sh_next[s];
                den_reg[s] <= den_src[s];
            end
        end
    end

    assign quo = sh_reg[STAGES_P-1];

endmodule

`default_nettype wire
